// ===== rtl/core/sndx_pkg.sv =====
// shared types, constants and the letter code table of the soundex encoder
package sndx_pkg;

   localparam int CHAR_WIDTH   = 8;
   localparam int LETTER_WIDTH = 7;
   localparam int CODE_WIDTH   = 3;
   localparam int DIGIT_COUNT  = 3;
   localparam int HELD_WIDTH   = 2;
   localparam int INDEX_WIDTH  = 5;

   localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] CASE_OFFSET   = 8'h20;

   localparam logic [CODE_WIDTH-1:0] CODE_NONE = 3'd0;
   localparam logic [CODE_WIDTH-1:0] CODE_LABIAL = 3'd1;
   localparam logic [CODE_WIDTH-1:0] CODE_GUTTURAL = 3'd2;
   localparam logic [CODE_WIDTH-1:0] CODE_DENTAL = 3'd3;
   localparam logic [CODE_WIDTH-1:0] CODE_LONG_LIQUID = 3'd4;
   localparam logic [CODE_WIDTH-1:0] CODE_NASAL = 3'd5;
   localparam logic [CODE_WIDTH-1:0] CODE_SHORT_LIQUID = 3'd6;

   localparam logic [HELD_WIDTH-1:0] HELD_FULL = 2'd3;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_in;
      logic                  last_char;
   } req_word_type;

   typedef struct packed {
      logic [LETTER_WIDTH-1:0] lead_letter;
      logic [CODE_WIDTH-1:0]   digit_one;
      logic [CODE_WIDTH-1:0]   digit_two;
      logic [CODE_WIDTH-1:0]   digit_three;
      logic                    no_letters;
   } rsp_word_type;

   typedef struct packed {
      logic                    is_letter;
      logic [LETTER_WIDTH-1:0] upper;
      logic [CODE_WIDTH-1:0]   code;
   } char_class_type;

   typedef struct packed {
      logic step;
      logic last;
   } step_ctrl_type;

   // letter index 0 is A
   function automatic logic [CODE_WIDTH-1:0] letter_code(input logic [INDEX_WIDTH-1:0] idx);
      logic [CODE_WIDTH-1:0] code;
      case (idx)
         5'd1, 5'd5, 5'd15, 5'd21: code = CODE_LABIAL;
         5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: code = CODE_GUTTURAL;
         5'd3, 5'd19: code = CODE_DENTAL;
         5'd11: code = CODE_LONG_LIQUID;
         5'd12, 5'd13: code = CODE_NASAL;
         5'd17: code = CODE_SHORT_LIQUID;
         default: code = CODE_NONE;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/core/sndx_char_map.sv =====
// classifies one character: letter test, upper-case fold and soundex code
module sndx_char_map (
   input  logic [sndx_pkg::CHAR_WIDTH-1:0] char_in,
   output sndx_pkg::char_class_type        char_class
);
   import sndx_pkg::*;

   logic [CHAR_WIDTH-1:0] folded;
   logic [CHAR_WIDTH-1:0] offset;

   always_comb begin
      if (char_in >= ASCII_LOWER_A && char_in <= ASCII_LOWER_Z) begin
         folded = char_in - CASE_OFFSET;
      end else begin
         folded = char_in;
      end
      offset = folded - ASCII_UPPER_A;
      char_class.is_letter = (folded >= ASCII_UPPER_A) && (folded <= ASCII_UPPER_Z);
      char_class.upper     = folded[LETTER_WIDTH-1:0];
      char_class.code      = letter_code(offset[INDEX_WIDTH-1:0]);
   end

endmodule

// ===== rtl/core/sndx_accum.sv =====
// per-name state: first letter, previous code and held digits
module sndx_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  sndx_pkg::step_ctrl_type  ctrl,
   input  sndx_pkg::char_class_type char_class,
   output sndx_pkg::rsp_word_type   result
);
   import sndx_pkg::*;

   logic                    seen_ff, seen_in;
   logic [LETTER_WIDTH-1:0] first_ff, first_in;
   logic [CODE_WIDTH-1:0]   prev_ff, prev_in;
   logic [HELD_WIDTH-1:0]   held_ff, held_in;
   logic [CODE_WIDTH-1:0]   digits_ff [DIGIT_COUNT];
   logic [CODE_WIDTH-1:0]   digits_in [DIGIT_COUNT];

   always_comb begin
      seen_in  = seen_ff;
      first_in = first_ff;
      prev_in  = prev_ff;
      held_in  = held_ff;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         digits_in[i] = digits_ff[i];
      end
      if (char_class.is_letter) begin
         if (!seen_ff) begin
            seen_in  = 1'b1;
            first_in = char_class.upper;
         end else if (char_class.code != CODE_NONE && char_class.code != prev_ff
                      && held_ff != HELD_FULL) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               if (held_ff == HELD_WIDTH'(i)) begin
                  digits_in[i] = char_class.code;
               end
            end
            held_in = held_ff + HELD_WIDTH'(1);
         end
         prev_in = char_class.code;
      end
      result.lead_letter = first_in;
      result.digit_one   = digits_in[0];
      result.digit_two   = digits_in[1];
      result.digit_three = digits_in[2];
      result.no_letters  = !seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.step && ctrl.last)) begin
         seen_ff  <= 1'b0;
         first_ff <= '0;
         prev_ff  <= CODE_NONE;
         held_ff  <= '0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digits_ff[i] <= CODE_NONE;
         end
      end else if (ctrl.step) begin
         seen_ff  <= seen_in;
         first_ff <= first_in;
         prev_ff  <= prev_in;
         held_ff  <= held_in;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digits_ff[i] <= digits_in[i];
         end
      end
   end

endmodule

// ===== rtl/core/soundex_name_encoder.sv =====
// soundex name encoder top level: input register, code update, result register
//
// a name streams in one character word per cycle on req_, the final one
// marked by last_char; letters of either case are coded, everything else is
// dropped without breaking a run of equal codes. one rsp_ word per name
// carries the upper-case lead letter, three zero-padded digits and a flag for
// a name with no letters. sustained rate is one character word per cycle
// while no final character is held back; the final character goes from
// the input register through the letter table and the code/state update
// into the result register, which drives rsp_. the block keeps taking
// characters while a result waits on rsp_stall; only a final character
// stalls, and only while the result register is still full and held.
module soundex_name_encoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sndx_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sndx_pkg::rsp_word_type rsp_word
);
   import sndx_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;

   char_class_type char_class;
   step_ctrl_type  ctrl;
   rsp_word_type   result;

   logic req_take;
   logic rsp_take;

   // a final character may only move on when the result register is free
   // or being emptied this cycle; other characters always move on
   always_comb begin
      rsp_take  = out_valid_ff && !rsp_stall;
      ctrl.last = in_word_ff.last_char;
      ctrl.step = in_valid_ff && (!in_word_ff.last_char || !out_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !ctrl.step;
      req_take  = req_valid && !req_stall;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (ctrl.step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (ctrl.step && ctrl.last) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (ctrl.step && ctrl.last) begin
         out_word_ff <= result;
      end
   end

   sndx_char_map u_char_map (
      .char_in    (in_word_ff.char_in),
      .char_class (char_class)
   );

   sndx_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .char_class (char_class),
      .result     (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
